>>> rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

    localparam int unsigned SECTOR_SPAN  = 43;
    localparam int unsigned FULL_SCALE   = 255;
    localparam int unsigned FRACTION_TOP = 42;
    localparam int unsigned SCALED_FULL  = 10710;
    localparam int unsigned LEVEL_SHIFT  = 8;
    // n / 42 == (n * RECIP_42) >> RECIP_SHIFT, exact for n < 27594
    localparam int unsigned RECIP_SHIFT  = 20;
    localparam int unsigned RECIP_42     = (1 << RECIP_SHIFT) / FRACTION_TOP + 1;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] frac;
    } split_t;

    // front end -> divide stage
    typedef struct packed {
        logic [2:0]  sector;
        logic        grey;
        logic [7:0]  v;
        logic [7:0]  p;
        logic [13:0] nq;    // 10710 - s*f
        logic [13:0] nt;    // 10710 - s*(42-f)
    } prod_t;

    // divide stage -> output stage
    typedef struct packed {
        logic [2:0] sector;
        logic       grey;
        logic [7:0] v;
        logic [7:0] p;
        logic [7:0] qd;
        logic [7:0] td;
    } lvl_t;

    // hue / 43 and hue % 43 by threshold compare
    function automatic split_t hue_split(input logic [7:0] h);
        split_t res;
        if (h >= 8'(5 * SECTOR_SPAN)) begin
            res.sector = SECTOR_5;
            res.frac   = 6'(h - 8'(5 * SECTOR_SPAN));
        end else if (h >= 8'(4 * SECTOR_SPAN)) begin
            res.sector = SECTOR_4;
            res.frac   = 6'(h - 8'(4 * SECTOR_SPAN));
        end else if (h >= 8'(3 * SECTOR_SPAN)) begin
            res.sector = SECTOR_3;
            res.frac   = 6'(h - 8'(3 * SECTOR_SPAN));
        end else if (h >= 8'(2 * SECTOR_SPAN)) begin
            res.sector = SECTOR_2;
            res.frac   = 6'(h - 8'(2 * SECTOR_SPAN));
        end else if (h >= 8'(SECTOR_SPAN)) begin
            res.sector = SECTOR_1;
            res.frac   = 6'(h - 8'(SECTOR_SPAN));
        end else begin
            res.sector = SECTOR_0;
            res.frac   = 6'(h);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hsvrgb_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: hue split. Stage 2: the three saturation products.
module hsvrgb_front
    import hsvrgb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en1,
    input  wire logic       en2,
    input  wire logic       vld_in,
    input  wire logic [7:0] hue,
    input  wire logic [7:0] saturation,
    input  wire logic [7:0] brightness,
    output logic            vld1,
    output logic            vld2,
    output prod_t           prod
);

    logic       vld1_reg, vld2_reg;
    logic [2:0] sector1_reg;
    logic [5:0] frac1_reg;
    logic [7:0] s1_reg, v1_reg;
    prod_t      prod_reg, prod_next;
    split_t     split;

    assign split = hue_split(hue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                vld1_reg <= vld_in;
            if (en2)
                vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sector1_reg <= split.sector;
            frac1_reg   <= split.frac;
            s1_reg      <= saturation;
            v1_reg      <= brightness;
        end
        if (en2)
            prod_reg <= prod_next;
    end

    always_comb
    begin
        logic [13:0] sf, sc;
        logic [15:0] vp;
        sf = 14'(s1_reg * frac1_reg);
        sc = 14'(s1_reg * (6'(FRACTION_TOP) - frac1_reg));
        vp = 16'(v1_reg * (8'(FULL_SCALE) - s1_reg));
        prod_next.sector = sector1_reg;
        prod_next.grey   = (s1_reg == 8'd0);
        prod_next.v      = v1_reg;
        prod_next.p      = vp[15:LEVEL_SHIFT];
        prod_next.nq     = 14'(SCALED_FULL) - sf;
        prod_next.nt     = 14'(SCALED_FULL) - sc;
    end

    assign vld1 = vld1_reg;
    assign vld2 = vld2_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/hsvrgb_div42.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 3: divide both numerators by 42 through a reciprocal multiply.
module hsvrgb_div42
    import hsvrgb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  vld_in,
    input  wire prod_t prod,
    output logic       vld,
    output lvl_t       lvl
);

    logic vld_reg;
    lvl_t lvl_reg, lvl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lvl_reg <= lvl_next;
    end

    always_comb
    begin
        logic [29:0] mq, mt;
        mq = 30'(prod.nq) * 30'(RECIP_42);
        mt = 30'(prod.nt) * 30'(RECIP_42);
        lvl_next.sector = prod.sector;
        lvl_next.grey   = prod.grey;
        lvl_next.v      = prod.v;
        lvl_next.p      = prod.p;
        lvl_next.qd     = mq[RECIP_SHIFT +: 8];
        lvl_next.td     = mt[RECIP_SHIFT +: 8];
    end

    assign vld = vld_reg;
    assign lvl = lvl_reg;

endmodule

`default_nettype wire

>>> rtl/hsvrgb_mix.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 4: scale q and t by value, route levels to channels, output register.
module hsvrgb_mix
    import hsvrgb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       vld_in,
    input  wire lvl_t       lvl,
    output logic            vld,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue
);

    logic       vld_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic [7:0] red_next, green_next, blue_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    always_comb
    begin
        logic [15:0] mq, mt;
        logic [7:0]  q, t;
        mq = 16'(lvl.v * lvl.qd);
        mt = 16'(lvl.v * lvl.td);
        q  = mq[15:LEVEL_SHIFT];
        t  = mt[15:LEVEL_SHIFT];
        red_next   = lvl.v;
        green_next = lvl.v;
        blue_next  = lvl.v;
        if (!lvl.grey)
        begin
            case (lvl.sector)
                SECTOR_0: begin red_next = lvl.v; green_next = t;     blue_next = lvl.p; end
                SECTOR_1: begin red_next = q;     green_next = lvl.v; blue_next = lvl.p; end
                SECTOR_2: begin red_next = lvl.p; green_next = lvl.v; blue_next = t;     end
                SECTOR_3: begin red_next = lvl.p; green_next = q;     blue_next = lvl.v; end
                SECTOR_4: begin red_next = t;     green_next = lvl.p; blue_next = lvl.v; end
                default:  begin red_next = lvl.v; green_next = lvl.p; blue_next = q;     end
            endcase
        end
    end

    assign vld   = vld_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

>>> rtl/hsv_to_rgb_converter.sv
// out_valid rises once an input transfer has passed the register stages below, later only while out_ready is low.
// Throughput: one conversion per cycle while out_ready is high; four register stages (hue split, saturation
//   products, reciprocal divide by 42, value scaling with channel routing).
// Each stage loads when it is empty or the stage after it moves, so stalls lose nothing.
// Reset (rst_n, async, active low) clears all stage valid bits; data regs are not reset.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] hue,
    input  wire logic [7:0] saturation,
    input  wire logic [7:0] brightness,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue
);

    // per-stage valid bits
    logic  vld1, vld2, vld3, vld4;
    // per-stage load enables: a stage takes new data when empty or draining
    logic  en1, en2, en3, en4;
    prod_t prod;
    lvl_t  lvl;

    assign en4 = !vld4 || out_ready;
    assign en3 = !vld3 || en4;
    assign en2 = !vld2 || en3;
    assign en1 = !vld1 || en2;

    assign in_ready  = en1;
    assign out_valid = vld4;

    // split hue into sector/fraction, then form s*f, s*(42-f), v*(255-s)
    hsvrgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en1        (en1),
        .en2        (en2),
        .vld_in     (in_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .vld1       (vld1),
        .vld2       (vld2),
        .prod       (prod)
    );

    // truncating divide by 42 for the q and t numerators
    hsvrgb_div42 u_div42 (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en3),
        .vld_in (vld2),
        .prod   (prod),
        .vld    (vld3),
        .lvl    (lvl)
    );

    // final value scaling and sector routing; doubles as the output register
    hsvrgb_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en4),
        .vld_in (vld3),
        .lvl    (lvl),
        .vld    (vld4),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

`ifndef SYNTHESIS
    // a free output side lets the whole pipe move
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline blocked while output is free");

    // an item held in stage 3 is not dropped during a stall
    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld3 && !en4) |=> vld3)
        else $error("stage 3 item lost during stall");

    // p never exceeds value
    a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld2 |-> (prod.p <= prod.v))
        else $error("p level above value");

    // q and t quotients stay within 8-bit full scale, and p stays at or below value
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld3 |-> (lvl.qd <= 8'(FULL_SCALE) && lvl.td <= 8'(FULL_SCALE) && lvl.p <= lvl.v))
        else $error("level out of range");
`endif

endmodule

`default_nettype wire

>>> dv/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
    import hsvrgb_pkg::*;

    // One pending HSV transfer; drain asks the sender to hold it back
    // until every outstanding conversion has come out.
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic       drain;
    } hsv_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam int unsigned RANDOM_ITEMS = 1625;
    localparam int unsigned CALM_TAIL    = 150;    // last items: no idling on either side
    localparam int unsigned HOLD_CYCLES  = 48;     // long receiver hold-off, fills the pipe
    localparam int unsigned SETTLE       = 12;     // pipe is 4 deep, allow some slack
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] hue        = 8'd0;
    logic [7:0] saturation = 8'd0;
    logic [7:0] brightness = 8'd0;
    logic       out_ready  = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    hsv_item_t   hsv_pending_q[$];
    rgb_t        rgb_expect_q[$];
    int unsigned items_total  = 0;
    int unsigned items_sent   = 0;
    int unsigned colors_seen  = 0;
    int unsigned fail_cnt     = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    logic [31:0] cycle_cnt    = '0;

    hsv_to_rgb_converter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Expected color for one HSV triple. Sector/fraction come straight from
    // divide and modulo here, unlike the threshold split in hardware, and all
    // products are kept at 32 bits so nothing wraps.
    function automatic rgb_t hsv_color(input logic [7:0] h, input logic [7:0] s,
                                       input logic [7:0] v);
        int unsigned hv;
        int unsigned sv;
        int unsigned vv;
        int unsigned frac;
        int unsigned lvl_p;
        int unsigned lvl_q;
        int unsigned lvl_t;
        logic [2:0]  sector;
        rgb_t        c;
        hv = h;
        sv = s;
        vv = v;
        c  = '{red: v, green: v, blue: v};    // grey when saturation is zero
        if (sv != 0) begin
            sector = 3'(hv / SECTOR_SPAN);
            frac   = hv % SECTOR_SPAN;
            lvl_p  = (vv * (FULL_SCALE - sv)) >> LEVEL_SHIFT;
            lvl_q  = (vv * ((SCALED_FULL - sv * frac) / FRACTION_TOP)) >> LEVEL_SHIFT;
            lvl_t  = (vv * ((SCALED_FULL - sv * (FRACTION_TOP - frac)) / FRACTION_TOP))
                     >> LEVEL_SHIFT;
            case (sector)
                SECTOR_0: c = '{red: v,          green: 8'(lvl_t), blue: 8'(lvl_p)};
                SECTOR_1: c = '{red: 8'(lvl_q),  green: v,         blue: 8'(lvl_p)};
                SECTOR_2: c = '{red: 8'(lvl_p),  green: v,         blue: 8'(lvl_t)};
                SECTOR_3: c = '{red: 8'(lvl_p),  green: 8'(lvl_q), blue: v};
                SECTOR_4: c = '{red: 8'(lvl_t),  green: 8'(lvl_p), blue: v};
                default:  c = '{red: v,          green: 8'(lvl_p), blue: 8'(lvl_q)};
            endcase
        end
        return c;
    endfunction

    function automatic logic quiet_phase();
        // Tail of the run, plus one window in four, runs without idling.
        return (hsv_pending_q.size() < CALM_TAIL) || (cycle_cnt[8:7] == 2'b11);
    endfunction

    task automatic queue_hsv(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                             input logic drain);
        hsv_pending_q.push_back('{hue: h, sat: s, val: v, drain: drain});
        items_total++;
    endtask

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // Sender: offers the next pending triple once the previous transfer is
    // done; valid and payload stay put while in_ready is low. Random idle
    // gaps follow some transfers.
    always @(posedge clk or negedge rst_n) begin
        hsv_item_t nxt;
        logic      advance;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            advance = !in_valid;
            if (in_valid && in_ready) begin
                rgb_expect_q.push_back(hsv_color(hue, saturation, brightness));
                items_sent++;
                advance = 1'b1;
                if (!quiet_phase() && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 3);
            end
            if (advance) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (hsv_pending_q.size() != 0 &&
                         !(hsv_pending_q[0].drain && rgb_expect_q.size() != 0)) begin
                    nxt = hsv_pending_q.pop_front();
                    hue        <= nxt.hue;
                    saturation <= nxt.sat;
                    brightness <= nxt.val;
                    in_valid   <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer against the oldest expected
    // color, stalls in short random bursts, and twice holds off long enough
    // for the four-stage pipe to back up into in_ready.
    always @(posedge clk or negedge rst_n) begin
        rgb_t want;
        logic ready_nxt;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (rgb_expect_q.size() == 0) begin
                    $error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
                    fail_cnt++;
                end
                else begin
                    want = rgb_expect_q.pop_front();
                    check_channel("red", want.red, red);
                    check_channel("green", want.green, green);
                    check_channel("blue", want.blue, blue);
                end
                colors_seen++;
                if (colors_seen == 300 || colors_seen == 900)
                    hold_left = HOLD_CYCLES;
            end
            ready_nxt = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                ready_nxt = 1'b0;
            end
            else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);    // start a random burst with out_ready low
                ready_nxt  = 1'b0;
            end
            out_ready <= ready_nxt;
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] v;

        // Directed: value/saturation extremes, grey, every sector boundary
        // at full saturation, the top of the hue range, smallest saturation.
        queue_hsv(8'd0,   8'd0,   8'd0,   1'b0);
        queue_hsv(8'd255, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd77,  8'd0,   8'd200, 1'b0);    // grey
        queue_hsv(8'd200, 8'd0,   8'd255, 1'b0);    // grey, full value
        queue_hsv(8'd0,   8'd255, 8'd255, 1'b0);
        queue_hsv(8'd42,  8'd255, 8'd255, 1'b0);
        queue_hsv(8'd43,  8'd255, 8'd255, 1'b0);
        queue_hsv(8'd85,  8'd255, 8'd255, 1'b0);
        queue_hsv(8'd86,  8'd255, 8'd255, 1'b0);
        queue_hsv(8'd128, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd129, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd171, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd172, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd214, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd215, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd254, 8'd255, 8'd255, 1'b0);
        queue_hsv(8'd255, 8'd1,   8'd255, 1'b0);    // faintest saturation
        queue_hsv(8'd100, 8'd255, 8'd0,   1'b0);    // value off
        queue_hsv(8'd21,  8'd128, 8'd128, 1'b0);
        queue_hsv(8'd64,  8'd170, 8'd1,   1'b0);
        queue_hsv(8'd150, 8'd85,  8'd254, 1'b0);
        queue_hsv(8'd190, 8'd254, 8'd77,  1'b0);
        queue_hsv(8'd240, 8'd60,  8'd180, 1'b0);

        // Random: mostly uniform, with extra weight on the field extremes.
        // Sender drains the pipe before the first random item and mid-run.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            h = 8'($urandom);
            case ($urandom_range(0, 7))
                0:       s = 8'd0;
                1:       s = 8'd255;
                default: s = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       v = 8'd0;
                1:       v = 8'd255;
                default: v = 8'($urandom);
            endcase
            queue_hsv(h, s, v, (i == 0) || (i == RANDOM_ITEMS / 2));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_sent != items_total) @(posedge clk);
        while (rgb_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_cnt == 0 && rgb_expect_q.size() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_front.sv
rtl/hsvrgb_div42.sv
rtl/hsvrgb_mix.sv
rtl/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_tb.sv
